// ===== rtl/core/arss_pkg.sv =====
// Shared constants and command/status types for the series sum unit.
`timescale 1ns / 1ps
package arss_pkg;
	localparam int FRAC_BITS = 16;
	localparam int MAX_TERMS = 4096;
	localparam int X_W = 32;
	localparam int EPS_W = 31;
	localparam int CNT_W = 13;
	localparam int TERM_W = FRAC_BITS;
	localparam int XSQ_W = 2 * X_W - FRAC_BITS;
	localparam int DVD_W = 2 * FRAC_BITS + 1;
	localparam int PROD_W = TERM_W + CNT_W + 1;
	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

	localparam logic [1:0] DSEL_T0 = 2'd0;
	localparam logic [1:0] DSEL_A = 2'd1;
	localparam logic [1:0] DSEL_B = 2'd2;

	typedef struct packed {
		logic load;
		logic square;
		logic start;
		logic [1:0] dsel;
		logic take_t0;
		logic step;
		logic take_a;
		logic take_b;
		logic emit;
	} arss_cmd_t;

	typedef struct packed {
		logic dom_err;
		logic div_done;
		logic cont;
	} arss_sts_t;
endpackage

// ===== rtl/core/atanh_reciprocal_series_sum_unit.sv =====
// Top level of the reciprocal odd power series sum unit.
//  channel  direction  signals
//  in       input      in_valid, in_ready, x_value
//  out      output     out_valid, out_ready, series_sum, term_count, domain_error,
//                      limit_reached
//  cfg      input      cfg_valid, cfg_ready, cfg_data (eps threshold)
// Two passes of the shared bit-serial divider dominate each term of an item.
// A domain error item skips the divider and goes straight to the result.
// Reset clears the controller and sets the threshold to its default.
// A finished result waits in the output register; a new item is taken meanwhile.
`timescale 1ns / 1ps
module atanh_reciprocal_series_sum_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [arss_pkg::X_W-1:0] x_value,
	output logic out_valid,
	input logic out_ready,
	output logic [arss_pkg::X_W-1:0] series_sum,
	output logic [arss_pkg::CNT_W-1:0] term_count,
	output logic domain_error,
	output logic limit_reached,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [arss_pkg::EPS_W-1:0] cfg_data
);
	import arss_pkg::*;

	arss_cmd_t cmd;
	arss_sts_t sts;

	assign cfg_ready = 1'b1;

	arss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.sts(sts)
	);

	arss_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_write(cfg_valid),
		.cfg_data(cfg_data),
		.x_value(x_value),
		.series_sum(series_sum),
		.term_count(term_count),
		.domain_error(domain_error),
		.limit_reached(limit_reached)
	);
endmodule

// ===== rtl/core/arss_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module arss_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [arss_pkg::DVD_W-1:0] dividend,
	input logic [arss_pkg::XSQ_W-1:0] divisor,
	output logic done,
	output logic [arss_pkg::DVD_W-1:0] quotient
);
	import arss_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic [XSQ_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [XSQ_W-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [XSQ_W:0] trial;
	logic fit;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fit = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? XSQ_W'(trial - {1'b0, dvs_q}) : trial[XSQ_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while still busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider failed to start");
endmodule

// ===== rtl/core/arss_dp.sv =====
// Datapath: argument, square, term, running sum, count and result registers.
`timescale 1ns / 1ps
module arss_dp (
	input logic clk,
	input logic arst_n,
	input arss_pkg::arss_cmd_t cmd,
	output arss_pkg::arss_sts_t sts,
	input logic cfg_write,
	input logic [arss_pkg::EPS_W-1:0] cfg_data,
	input logic [arss_pkg::X_W-1:0] x_value,
	output logic [arss_pkg::X_W-1:0] series_sum,
	output logic [arss_pkg::CNT_W-1:0] term_count,
	output logic domain_error,
	output logic limit_reached
);
	import arss_pkg::*;

	localparam logic [X_W-1:0] ONE = X_W'(1) << FRAC_BITS;
	localparam logic [X_W-1:0] NEG_LIM = X_W'(1) << (X_W - 1);
	localparam logic [X_W-1:0] POS_LIM = NEG_LIM - 1'b1;

	logic [EPS_W-1:0] eps_q;
	logic neg_q;
	logic [X_W-1:0] mag_q;
	logic [XSQ_W-1:0] xsq_q;
	logic [TERM_W-1:0] term_q;
	logic [TERM_W-1:0] scaled_q;
	logic [PROD_W-1:0] prod_q;
	logic [X_W-1:0] sum_q;
	logic [CNT_W-1:0] n_q;
	logic [2*X_W-1:0] sq_full;
	logic [DVD_W-1:0] dvd;
	logic [XSQ_W-1:0] dvs;
	logic div_done;
	logic [DVD_W-1:0] quo;
	logic dom;
	logic above;
	logic [X_W-1:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_write) begin
			eps_q <= cfg_data;
		end
	end

	assign sq_full = mag_q * mag_q;
	assign dom = mag_q <= ONE;
	assign above = {{(EPS_W-TERM_W){1'b0}}, term_q} >= eps_q;

	always_comb begin
		case (cmd.dsel)
			DSEL_T0: begin
				dvd = DVD_W'(1) << (2 * FRAC_BITS);
				dvs = XSQ_W'(mag_q);
			end
			DSEL_A: begin
				dvd = DVD_W'(prod_q);
				dvs = XSQ_W'({n_q, 1'b1});
			end
			DSEL_B: begin
				dvd = DVD_W'({scaled_q, {FRAC_BITS{1'b0}}});
				dvs = xsq_q;
			end
			default: begin
				dvd = '0;
				dvs = xsq_q;
			end
		endcase
	end

	arss_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.start),
		.dividend(dvd),
		.divisor(dvs),
		.done(div_done),
		.quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= x_value[X_W-1];
			mag_q <= x_value[X_W-1] ? X_W'(~x_value + 1'b1) : x_value;
			n_q <= '0;
		end
		if (cmd.square) begin
			xsq_q <= sq_full[2*X_W-1:FRAC_BITS];
		end
		if (cmd.take_t0) begin
			term_q <= quo[TERM_W-1:0];
			sum_q <= X_W'(quo[TERM_W-1:0]);
		end
		if (cmd.step) begin
			n_q <= n_q + 1'b1;
			prod_q <= PROD_W'(term_q) * PROD_W'({n_q, 1'b1});
		end
		if (cmd.take_a) begin
			scaled_q <= quo[TERM_W-1:0];
		end
		if (cmd.take_b) begin
			term_q <= quo[TERM_W-1:0];
			sum_q <= sum_q + X_W'(quo[TERM_W-1:0]);
		end
	end

	always_comb begin
		if (neg_q) begin
			sat = (sum_q > NEG_LIM) ? NEG_LIM : sum_q;
			sat = X_W'(~sat + 1'b1);
		end else begin
			sat = (sum_q > POS_LIM) ? POS_LIM : sum_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			series_sum <= dom ? '0 : sat;
			term_count <= dom ? '0 : n_q;
			domain_error <= dom;
			limit_reached <= dom ? 1'b0 : above;
		end
	end

	assign sts.dom_err = dom;
	assign sts.div_done = div_done;
	assign sts.cont = above && (n_q < CNT_W'(MAX_TERMS));
endmodule

// ===== rtl/core/arss_ctrl.sv =====
// Controller sequencing the reciprocal divide and term update per item.
`timescale 1ns / 1ps
module arss_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output arss_pkg::arss_cmd_t cmd,
	input arss_pkg::arss_sts_t sts
);
	import arss_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK = 4'd1;
	localparam logic [3:0] S_D0 = 4'd2;
	localparam logic [3:0] S_W0 = 4'd3;
	localparam logic [3:0] S_MUL = 4'd4;
	localparam logic [3:0] S_DA = 4'd5;
	localparam logic [3:0] S_WA = 4'd6;
	localparam logic [3:0] S_DB = 4'd7;
	localparam logic [3:0] S_WB = 4'd8;
	localparam logic [3:0] S_TST = 4'd9;
	localparam logic [3:0] S_FIN = 4'd10;

	logic [3:0] st_q;
	logic [3:0] st_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = st_q == S_IDLE;

	always_comb begin
		st_d = st_q;
		cmd = '0;
		cmd.dsel = DSEL_T0;
		case (st_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) st_d = S_CHK;
			end
			S_CHK: begin
				cmd.square = 1'b1;
				st_d = sts.dom_err ? S_FIN : S_D0;
			end
			S_D0: begin
				cmd.start = 1'b1;
				st_d = S_W0;
			end
			S_W0: begin
				cmd.take_t0 = sts.div_done;
				if (sts.div_done) st_d = S_MUL;
			end
			S_MUL: begin
				cmd.step = 1'b1;
				st_d = S_DA;
			end
			S_DA: begin
				cmd.dsel = DSEL_A;
				cmd.start = 1'b1;
				st_d = S_WA;
			end
			S_WA: begin
				cmd.take_a = sts.div_done;
				if (sts.div_done) st_d = S_DB;
			end
			S_DB: begin
				cmd.dsel = DSEL_B;
				cmd.start = 1'b1;
				st_d = S_WB;
			end
			S_WB: begin
				cmd.take_b = sts.div_done;
				if (sts.div_done) st_d = S_TST;
			end
			S_TST: begin
				st_d = sts.cont ? S_MUL : S_FIN;
			end
			S_FIN: begin
				cmd.emit = slot_free;
				if (slot_free) st_d = S_IDLE;
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |=> out_valid_q)
		else $error("result not presented after emit");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WA) && !sts.div_done |=> st_q == S_WA)
		else $error("left divide wait early");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");
endmodule

// ===== tb/tb_atanh_reciprocal_series_sum_unit.sv =====
// Self-checking testbench for the reciprocal odd power series sum unit.
`timescale 1ns / 1ps
module tb_atanh_reciprocal_series_sum_unit;
	import arss_pkg::*;

	localparam longint CYCLE_LIMIT = 8000000;
	localparam logic [EPS_W-1:0] EPS_MAX = {EPS_W{1'b1}};

	typedef struct {
		logic [X_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
		logic dom;
		logic lim;
	} series_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [X_W-1:0] x_value;
	logic out_valid;
	logic out_ready;
	logic [X_W-1:0] series_sum;
	logic [CNT_W-1:0] term_count;
	logic domain_error;
	logic limit_reached;
	logic cfg_valid;
	logic cfg_ready;
	logic [EPS_W-1:0] cfg_data;

	series_result_t series_expect_q[$];
	logic [EPS_W-1:0] eps_model;
	int error_count;
	bit idle_on;
	int hold_left;
	int gap_left;
	longint cycle_count;

	atanh_reciprocal_series_sum_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_value(x_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.series_sum(series_sum),
		.term_count(term_count),
		.domain_error(domain_error),
		.limit_reached(limit_reached),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_atanh_reciprocal_series_sum_unit failed");
			$finish;
		end
	end

	function automatic series_result_t series_sum_of(input logic [X_W-1:0] x,
			input logic [EPS_W-1:0] eps);
		series_result_t r;
		longint unsigned mag;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned xsq;
		longint unsigned n;
		logic [X_W-1:0] negx;
		bit neg;
		neg = x[X_W-1];
		negx = -x;
		mag = neg ? longint'(negx) : longint'(x);
		r.sum = '0;
		r.cnt = '0;
		r.dom = 1'b0;
		r.lim = 1'b0;
		if (mag <= (64'd1 << FRAC_BITS)) begin
			r.dom = 1'b1;
			return r;
		end
		term = (64'd1 << (2 * FRAC_BITS)) / mag;
		acc = term;
		xsq = (mag * mag) >> FRAC_BITS;
		n = 0;
		do begin
			n++;
			term = (((term * (2 * n - 1)) / (2 * n + 1)) << FRAC_BITS) / xsq;
			acc += term;
		end while (term >= eps && n < MAX_TERMS);
		r.lim = term >= eps;
		if (neg) begin
			if (acc > 64'h8000_0000)
				acc = 64'h8000_0000;
			r.sum = -acc[X_W-1:0];
		end else begin
			if (acc > 64'h7FFF_FFFF)
				acc = 64'h7FFF_FFFF;
			r.sum = acc[X_W-1:0];
		end
		r.cnt = n[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("mismatch on %s: got %0h, expected %0h", what, got, exp);
		error_count++;
	endtask

	always @(posedge clk) begin
		series_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (series_expect_q.size() == 0) begin
				report_mismatch("unexpected item", series_sum, 0);
			end else begin
				e = series_expect_q.pop_front();
				if (series_sum !== e.sum)
					report_mismatch("series_sum", series_sum, e.sum);
				if (term_count !== e.cnt)
					report_mismatch("term_count", term_count, e.cnt);
				if (domain_error !== e.dom)
					report_mismatch("domain_error", domain_error, e.dom);
				if (limit_reached !== e.lim)
					report_mismatch("limit_reached", limit_reached, e.lim);
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		gap_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				gap_left = $urandom_range(1, 3) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_x(input logic [X_W-1:0] x);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_value <= x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		series_expect_q.push_back(series_sum_of(x, eps_model));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (series_expect_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_eps(input logic [EPS_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		eps_model = v;
	endtask

	function automatic logic [X_W-1:0] random_x();
		logic [X_W-1:0] m;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			m = $urandom_range(0, 1 << FRAC_BITS);
		else if (pick < 24)
			m = $urandom_range(3 << (FRAC_BITS - 1), 4 << FRAC_BITS);
		else if (pick < 40)
			m = $urandom_range(4 << FRAC_BITS, 32'h00FF_FFFF);
		else
			return $urandom;
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	task automatic test_directed_default_eps();
		logic [X_W-1:0] xs[12] = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0001,
			32'hFFFE_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000,
			32'hFFFE_0000, 32'h1, 32'hFFFF_FFFF, 32'h8000_0001};
		foreach (xs[i])
			send_x(xs[i]);
		drain();
	endtask

	task automatic test_directed_eps_extremes();
		write_eps(EPS_W'(1));
		send_x(32'h0001_0001);
		send_x(32'h8000_0000);
		send_x(32'h0001_8000);
		send_x(32'hFFFE_8000);
		drain();
		write_eps(EPS_MAX);
		send_x(32'h0001_0001);
		send_x(-32'd200000);
		send_x(32'h7FFF_FFFF);
		drain();
	endtask

	task automatic test_random_phase(input logic [EPS_W-1:0] eps, input int count);
		write_eps(eps);
		repeat (count)
			send_x(random_x());
		drain();
	endtask

	task automatic test_output_backpressure();
		write_eps(EPS_W'(66));
		hold_left = 600;
		repeat (12)
			send_x(32'hFFFE_0000 - $urandom_range(0, 32'h00FF_FFFF));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_left = 0;
		error_count = 0;
		cycle_count = 0;
		eps_model = EPS_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_default_eps();
		test_directed_eps_extremes();
		test_random_phase(EPS_W'(1), 400);
		test_random_phase(EPS_W'($urandom_range(1, 5000)), 350);
		test_output_backpressure();
		test_random_phase(EPS_MAX, 300);
		test_random_phase(EPS_W'($urandom_range(1, EPS_MAX)), 300);
		idle_on = 1'b0;
		test_random_phase(EPS_W'(66), 350);
		if (error_count == 0)
			$display("tb_atanh_reciprocal_series_sum_unit passed");
		else
			$display("tb_atanh_reciprocal_series_sum_unit failed");
		$finish;
	end
endmodule
